// ----- rtl/core/dpft_pkg.sv -----
`default_nettype none

package dpft_pkg;

    // Default geometry and colour depth
    localparam int GRID_WIDTH_DEF  = 16;
    localparam int GRID_HEIGHT_DEF = 16;
    localparam int COLOR_BITS_DEF  = 4;

    // Fixed field widths on the stream ports
    localparam int COORD_W     = 4;
    localparam int COLOR_IN_W  = 4;
    localparam int OFFSET_W    = 8;
    localparam int COLOR_OUT_W = 4;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 16;

    // Item kinds carried on tuser
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clear_step;   // write one zero entry of the colour store
        logic capture;      // item accepted: latch fields, issue reads
        logic wr_commit;    // finish a pixel write
        logic dr_pick;      // choose the dirty column, clear its mark
        logic dr_emit;      // copy pending to shown, load the result
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clear_last;   // last entry of the clearing pass
        logic write_ok;     // incoming coordinates lie inside the grid
        logic any_dirty;    // at least one pixel is marked
        logic out_free;     // result register can take a new item
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- rtl/core/dpft_ram.sv -----
`default_nettype none

module dpft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/core/dpft_ctrl.sv -----
`default_nettype none

module dpft_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic               i_opcode,
    input  wire dpft_pkg::t_dp_stat i_stat,
    output logic                    o_ready,
    output dpft_pkg::t_dp_cmd       o_cmd
);
    import dpft_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WR_CHECK,
        S_DR_ROW,
        S_DR_COLOR
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = o_ready && i_valid;

    always_comb begin
        o_cmd            = '0;
        n_state          = r_state;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.capture = accept;
                if (accept) begin
                    if (i_opcode == OP_DRAIN) begin
                        if (i_stat.any_dirty) begin
                            n_state = S_DR_ROW;
                        end
                    end else if (i_stat.write_ok) begin
                        n_state = S_WR_CHECK;
                    end
                end
            end
            S_WR_CHECK: begin
                o_cmd.wr_commit = 1'b1;
                n_state         = S_IDLE;
            end
            S_DR_ROW: begin
                o_cmd.dr_pick = 1'b1;
                n_state       = S_DR_COLOR;
            end
            S_DR_COLOR: begin
                if (i_stat.out_free) begin
                    o_cmd.dr_emit = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/dpft_datapath.sv -----
`default_nettype none

module dpft_datapath #(
    parameter int GRID_WIDTH  = dpft_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = dpft_pkg::GRID_HEIGHT_DEF,
    parameter int COLOR_BITS  = dpft_pkg::COLOR_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic [dpft_pkg::S_TDATA_W-1:0]   i_tdata,
    input  wire logic                             i_opcode,
    input  wire dpft_pkg::t_dp_cmd                i_cmd,
    output dpft_pkg::t_dp_stat                    o_stat,
    input  wire logic                             i_m_ready,
    output logic                                  o_m_valid,
    output logic      [dpft_pkg::OFFSET_W-1:0]    o_m_offset,
    output logic      [dpft_pkg::COLOR_OUT_W-1:0] o_m_color,
    output logic                                  o_m_last
);
    import dpft_pkg::*;

    localparam int CELL_COUNT = GRID_WIDTH * GRID_HEIGHT;
    localparam int CELL_W     = $clog2(CELL_COUNT);
    localparam int ROW_W      = $clog2(GRID_HEIGHT);
    localparam int COL_W      = $clog2(GRID_WIDTH);
    localparam int CNT_W      = $clog2(CELL_COUNT + 1);

    // Incoming fields
    logic [COORD_W-1:0]    in_x;
    logic [COORD_W-1:0]    in_y;
    logic [COLOR_IN_W-1:0] in_c;
    logic [CELL_W-1:0]     in_cell;

    assign in_x    = i_tdata[COORD_W-1:0];
    assign in_y    = i_tdata[2*COORD_W-1:COORD_W];
    assign in_c    = i_tdata[2*COORD_W+COLOR_IN_W-1:2*COORD_W];
    assign in_cell = CELL_W'(ROW_W'(in_y)) * CELL_W'(GRID_WIDTH) + CELL_W'(COL_W'(in_x));

    // Control state
    logic [GRID_HEIGHT-1:0] r_row_flag;
    logic [CNT_W-1:0]       r_count;
    logic [CELL_W-1:0]      r_sweep;
    logic                   r_m_valid;

    // Captured item
    logic [COL_W-1:0]       r_col;
    logic [ROW_W-1:0]       r_row_idx;
    logic [COLOR_BITS-1:0]  r_color;
    logic [CELL_W-1:0]      r_cell;
    logic                   r_last;

    // Result register
    logic [OFFSET_W-1:0]    r_m_offset;
    logic [COLOR_OUT_W-1:0] r_m_color;
    logic                   r_m_last;

    // First marked row, lowest index wins
    logic [ROW_W-1:0] first_row;
    always_comb begin
        first_row = '0;
        for (int i = GRID_HEIGHT - 1; i >= 0; i--) begin
            if (r_row_flag[i]) begin
                first_row = ROW_W'(i);
            end
        end
    end

    // Dirty rows store
    logic [GRID_WIDTH-1:0] row_rdata;
    logic [GRID_WIDTH-1:0] row_data;
    logic [GRID_WIDTH-1:0] row_wdata;
    logic                  row_we;
    logic [ROW_W-1:0]      row_raddr;

    assign row_raddr = (i_opcode == OP_DRAIN) ? first_row : ROW_W'(in_y);
    // a row whose flag is clear reads as empty
    assign row_data  = r_row_flag[r_row_idx] ? row_rdata : '0;

    dpft_ram #(
        .WIDTH (GRID_WIDTH),
        .DEPTH (GRID_HEIGHT)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (r_row_idx),
        .i_wdata (row_wdata),
        .i_re    (i_cmd.capture),
        .i_raddr (row_raddr),
        .o_rdata (row_rdata)
    );

    // Colour store: shown in the upper half, pending in the lower
    logic [2*COLOR_BITS-1:0] col_rdata;
    logic [2*COLOR_BITS-1:0] col_wdata;
    logic [CELL_W-1:0]       col_waddr;
    logic [CELL_W-1:0]       col_raddr;
    logic                    col_we;
    logic [COLOR_BITS-1:0]   shown;
    logic [COLOR_BITS-1:0]   pend;

    assign shown = col_rdata[2*COLOR_BITS-1:COLOR_BITS];
    assign pend  = col_rdata[COLOR_BITS-1:0];

    dpft_ram #(
        .WIDTH (2 * COLOR_BITS),
        .DEPTH (CELL_COUNT)
    ) u_color_ram (
        .i_clk   (i_clk),
        .i_we    (col_we),
        .i_waddr (col_waddr),
        .i_wdata (col_wdata),
        .i_re    (i_cmd.capture || i_cmd.dr_pick),
        .i_raddr (col_raddr),
        .o_rdata (col_rdata)
    );

    // Write decision and drain pick
    logic                  take;
    logic                  was_dirty;
    logic [GRID_WIDTH-1:0] set_mask;
    logic [COL_W-1:0]      pick_col;
    logic [GRID_WIDTH-1:0] pick_mask;
    logic [GRID_WIDTH-1:0] row_left;
    logic [CELL_W-1:0]     pick_cell;

    assign take      = (shown != r_color) && (pend != r_color);
    assign set_mask  = GRID_WIDTH'(1) << r_col;
    assign was_dirty = row_data[r_col];

    always_comb begin
        pick_col = '0;
        for (int i = GRID_WIDTH - 1; i >= 0; i--) begin
            if (row_data[i]) begin
                pick_col = COL_W'(i);
            end
        end
    end

    assign pick_mask = GRID_WIDTH'(1) << pick_col;
    assign row_left  = row_data & ~pick_mask;
    assign pick_cell = CELL_W'(r_row_idx) * CELL_W'(GRID_WIDTH) + CELL_W'(pick_col);

    always_comb begin
        row_we    = 1'b0;
        row_wdata = row_data | set_mask;
        if (i_cmd.wr_commit && take) begin
            row_we = 1'b1;
        end else if (i_cmd.dr_pick) begin
            row_we    = 1'b1;
            row_wdata = row_left;
        end
    end

    always_comb begin
        col_raddr = i_cmd.dr_pick ? pick_cell : in_cell;
        col_we    = 1'b0;
        col_waddr = r_cell;
        col_wdata = {shown, r_color};
        if (i_cmd.clear_step) begin
            col_we    = 1'b1;
            col_waddr = r_sweep;
            col_wdata = '0;
        end else if (i_cmd.wr_commit && take) begin
            col_we = 1'b1;
        end else if (i_cmd.dr_emit) begin
            col_we    = 1'b1;
            col_wdata = {pend, pend};
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_flag <= '0;
            r_count    <= '0;
            r_sweep    <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            if (i_cmd.clear_step) begin
                r_sweep <= r_sweep + CELL_W'(1);
            end
            if (i_cmd.wr_commit && take) begin
                r_row_flag[r_row_idx] <= 1'b1;
                if (!was_dirty) begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
            if (i_cmd.dr_pick) begin
                r_count <= r_count - CNT_W'(1);
                if (row_left == '0) begin
                    r_row_flag[r_row_idx] <= 1'b0;
                end
            end
            if (i_cmd.dr_emit) begin
                r_m_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_col     <= COL_W'(in_x);
            r_row_idx <= row_raddr;
            r_color   <= COLOR_BITS'(in_c);
            r_cell    <= in_cell;
        end
        if (i_cmd.dr_pick) begin
            r_cell <= pick_cell;
            r_last <= (r_count == CNT_W'(1));
        end
        if (i_cmd.dr_emit) begin
            r_m_offset <= OFFSET_W'(r_cell);
            r_m_color  <= COLOR_OUT_W'(pend);
            r_m_last   <= r_last;
        end
    end

    assign o_stat.clear_last = (r_sweep == CELL_W'(CELL_COUNT - 1));
    assign o_stat.write_ok   = (32'(in_x) < 32'(GRID_WIDTH)) && (32'(in_y) < 32'(GRID_HEIGHT));
    assign o_stat.any_dirty  = (r_count != '0);
    assign o_stat.out_free   = !r_m_valid || i_m_ready;

    assign o_m_valid  = r_m_valid;
    assign o_m_offset = r_m_offset;
    assign o_m_color  = r_m_color;
    assign o_m_last   = r_m_last;

`ifndef SYNTHESIS
    a_count_matches_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) == (r_row_flag == '0))
        else $error("dirty count disagrees with row flags");

    a_pick_has_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.dr_pick |-> (row_data != '0))
        else $error("drain picked a row with no dirty pixel");

    a_emit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.dr_emit |-> (!r_m_valid || i_m_ready))
        else $error("result overwritten before it was taken");

    a_emit_after_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.dr_pick |=> !i_cmd.capture)
        else $error("new item accepted in the middle of a drain");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/dirty_pixel_flush_tracker.sv -----
// Dirty-pixel flush tracker for a GRID_WIDTH x GRID_HEIGHT display with
// COLOR_BITS-bit colours. A write item (tuser = 0) stores its colour as
// pending and marks the pixel dirty only when it differs from both the shown
// and the pending colour; writes outside the grid are dropped. A drain item
// (tuser = 1) sends out the lowest-offset dirty pixel with its pending colour,
// copies that colour into the shown frame and clears the mark; tlast is set
// when nothing stays dirty. A drain with nothing dirty gives no result.
// A write reads and then writes the colour store. A drain reads the dirty
// row, then the colour, then updates, holding the update while the output
// register is full; a write outside the grid or an empty drain ends when
// taken. A finished result sits in an output register, so the next item is
// taken while it waits. After reset the colour store is cleared one entry
// a cycle, all GRID_WIDTH*GRID_HEIGHT (256 by default), before any item.
`default_nettype none

module dirty_pixel_flush_tracker #(
    parameter int GRID_WIDTH  = dpft_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = dpft_pkg::GRID_HEIGHT_DEF,
    parameter int COLOR_BITS  = dpft_pkg::COLOR_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // slave side
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // tdata: pos_x [3:0], pos_y [7:4], pixel_color [11:8], zero [15:12]
    input  wire logic [dpft_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // tuser: opcode (0 = write pixel, 1 = drain)
    input  wire logic                           i_s_axis_tuser,
    // master side
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    // tdata: pixel_offset [7:0], flushed_color [11:8], zero [15:12]
    output logic      [dpft_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    output logic                                o_m_axis_tlast
);
    import dpft_pkg::*;

    t_dp_cmd                cmd;
    t_dp_stat               stat;
    logic [OFFSET_W-1:0]    m_offset;
    logic [COLOR_OUT_W-1:0] m_color;

    dpft_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .i_opcode (i_s_axis_tuser),
        .i_stat   (stat),
        .o_ready  (o_s_axis_tready),
        .o_cmd    (cmd)
    );

    dpft_datapath #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT),
        .COLOR_BITS  (COLOR_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tdata    (i_s_axis_tdata),
        .i_opcode   (i_s_axis_tuser),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_m_ready  (i_m_axis_tready),
        .o_m_valid  (o_m_axis_tvalid),
        .o_m_offset (m_offset),
        .o_m_color  (m_color),
        .o_m_last   (o_m_axis_tlast)
    );

    // pack result fields, lowest field first, zero fill to whole bytes
    assign o_m_axis_tdata = M_TDATA_W'({m_color, m_offset});

endmodule

`default_nettype wire

// ----- tb/dirty_pixel_flush_tracker_tb.sv -----
`timescale 1ns / 100ps

module dirty_pixel_flush_tracker_tb;

    import dpft_pkg::*;

    localparam int GRID_W      = GRID_WIDTH_DEF;
    localparam int GRID_H      = GRID_HEIGHT_DEF;
    localparam int PIXELS      = GRID_W * GRID_H;
    // Cycles with no item moving on either side before the run is abandoned.
    // Covers the clearing pass after reset with a wide margin.
    localparam int QUIET_LIMIT = 4000;
    localparam int ITEMS_PHASE = 570;
    localparam int HOT_PIXELS  = 8;
    localparam int MAX_REPORTS = 40;

    // One flushed pixel as seen on the master side
    typedef struct packed {
        logic [OFFSET_W-1:0]    offset;
        logic [COLOR_OUT_W-1:0] color;
        logic                   last;
    } t_flush_rec;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    // tdata: pos_x [3:0], pos_y [7:4], pixel_color [11:8], zero [15:12]
    logic [S_TDATA_W-1:0] i_s_axis_tdata;
    // tuser: opcode (OP_WRITE / OP_DRAIN)
    logic                 i_s_axis_tuser;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    // tdata: pixel_offset [7:0], flushed_color [11:8], zero [15:12]
    logic [M_TDATA_W-1:0] o_m_axis_tdata;
    logic                 o_m_axis_tlast;

    // Shadow of the display state, advanced on every accepted item
    logic [COLOR_IN_W-1:0] shown_px   [PIXELS];
    logic [COLOR_IN_W-1:0] pending_px [PIXELS];
    logic                  dirty_px   [PIXELS];

    t_flush_rec flush_queue[$];

    int items_taken    = 0;
    int error_count    = 0;
    int quiet_cycles   = 0;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;

    dirty_pixel_flush_tracker dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: applies one accepted item to the shadow state and queues
    // the flushed pixel a drain produces.
    // ------------------------------------------------------------------
    task automatic track_item(input logic op, input logic [COORD_W-1:0] px,
                              input logic [COORD_W-1:0] py,
                              input logic [COLOR_IN_W-1:0] colour);
        int         idx;
        int         pick;
        logic       more;
        t_flush_rec rec;
        if (op == OP_WRITE) begin
            // coordinates beyond the grid are dropped (unreachable at 16x16)
            if (int'(px) < GRID_W && int'(py) < GRID_H) begin
                idx = int'(py) * GRID_W + int'(px);
                if (shown_px[idx] != colour && pending_px[idx] != colour) begin
                    pending_px[idx] = colour;
                    dirty_px[idx]   = 1'b1;
                end
            end
        end else begin
            pick = -1;
            for (int i = 0; i < PIXELS; i++) begin
                if (dirty_px[i]) begin
                    pick = i;
                    break;
                end
            end
            // empty drain: nothing comes out, nothing changes
            if (pick >= 0) begin
                shown_px[pick] = pending_px[pick];
                dirty_px[pick] = 1'b0;
                more = 1'b0;
                for (int i = pick + 1; i < PIXELS; i++)
                    if (dirty_px[i]) more = 1'b1;
                rec.offset = pick[OFFSET_W-1:0];
                rec.color  = pending_px[pick];
                rec.last   = !more;
                flush_queue.push_back(rec);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input int want, input int got);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("MISMATCH @%0t: %s expected %0d got %0d", $realtime, what, want, got);
    endtask

    task automatic check_flush();
        t_flush_rec want;
        if (flush_queue.size() == 0) begin
            report_mismatch("unexpected flush item, offset", -1, int'(o_m_axis_tdata[7:0]));
        end else begin
            want = flush_queue.pop_front();
            if (o_m_axis_tdata[7:0] != want.offset)
                report_mismatch("pixel_offset", int'(want.offset),
                                int'(o_m_axis_tdata[7:0]));
            if (o_m_axis_tdata[11:8] != want.color)
                report_mismatch("flushed_color", int'(want.color),
                                int'(o_m_axis_tdata[11:8]));
            if (o_m_axis_tlast != want.last)
                report_mismatch("last", int'(want.last), int'(o_m_axis_tlast));
        end
    endtask

    // Both handshakes sampled at the rising edge; inputs only move at the
    // falling edge, so nothing here races the block.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                items_taken++;
                track_item(i_s_axis_tuser, i_s_axis_tdata[3:0],
                           i_s_axis_tdata[7:4], i_s_axis_tdata[11:8]);
            end
            if (o_m_axis_tvalid && i_m_axis_tready)
                check_flush();
        end
    end

    // Watchdog on cycles where no item moves on either side
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver back-pressure
    always @(negedge i_clk)
        i_m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);

    // ------------------------------------------------------------------
    // Sends one item. Called at a falling edge, returns at the falling edge
    // after the item was taken, with tvalid still high so back-to-back
    // items need no extra assignment.
    // ------------------------------------------------------------------
    task automatic send_pixel_item(input logic op, input logic [COORD_W-1:0] px,
                                   input logic [COORD_W-1:0] py,
                                   input logic [COLOR_IN_W-1:0] colour);
        int taken_at;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= {4'b0000, colour, py, px};
        taken_at = items_taken;
        do @(negedge i_clk); while (items_taken == taken_at);
    endtask

    task automatic drain_one();
        // position and colour are don't-care on a drain; randomise them
        send_pixel_item(OP_DRAIN, COORD_W'($urandom), COORD_W'($urandom),
                        COLOR_IN_W'($urandom));
    endtask

    // Write rules: equal-to-shown, equal-to-pending, overwrite of a dirty
    // pixel, then drain ordering by offset, tlast and the empty drain.
    task automatic test_write_rules();
        drain_one();                                       // nothing dirty yet
        send_pixel_item(OP_WRITE, 4'd0,  4'd0,  4'd0);     // equals shown: dropped
        send_pixel_item(OP_WRITE, 4'd15, 4'd15, 4'd15);
        send_pixel_item(OP_WRITE, 4'd0,  4'd0,  4'd15);
        send_pixel_item(OP_WRITE, 4'd15, 4'd15, 4'd15);    // equals pending: dropped
        send_pixel_item(OP_WRITE, 4'd15, 4'd15, 4'd0);     // shown colour on dirty pixel
        send_pixel_item(OP_WRITE, 4'd15, 4'd15, 4'd9);     // replaces pending
        send_pixel_item(OP_WRITE, 4'd10, 4'd5,  4'd10);
        send_pixel_item(OP_WRITE, 4'd5,  4'd10, 4'd5);
        send_pixel_item(OP_WRITE, 4'd10, 4'd5,  4'd6);     // re-marked pixel keeps its place
        repeat (5) drain_one();                            // last one finds nothing
    endtask

    task automatic test_drain_order();
        send_pixel_item(OP_WRITE, 4'd0,  4'd0, 4'd15);     // equals shown now: dropped
        send_pixel_item(OP_WRITE, 4'd0,  4'd0, 4'd0);
        send_pixel_item(OP_WRITE, 4'd0,  4'd0, 4'd15);     // back to shown: dropped
        send_pixel_item(OP_WRITE, 4'd7,  4'd8, 4'd3);
        send_pixel_item(OP_WRITE, 4'd15, 4'd0, 4'd12);
        repeat (4) drain_one();
    endtask

    // Random traffic around a few hot pixels so that overwrites and the
    // shown/pending comparisons come up often; occasional drain bursts
    // empty the map and run into empty drains.
    task automatic test_random_traffic(input int src_idle, input int sink_stall);
        logic [7:0]            hot [HOT_PIXELS];
        logic [7:0]            pix;
        logic [COLOR_IN_W-1:0] colour;
        int                    roll;
        int                    sent;
        int                    burst;
        src_idle_pct   = src_idle;
        sink_stall_pct = sink_stall;
        foreach (hot[i]) hot[i] = 8'($urandom);
        sent = 0;
        while (sent < ITEMS_PHASE) begin
            roll = $urandom_range(0, 99);
            if (roll < 4) begin
                burst = $urandom_range(2, 24);
                repeat (burst) drain_one();
                sent += burst;
            end else if (roll < 38) begin
                drain_one();
                sent++;
            end else begin
                pix = $urandom_range(0, 1) ? hot[$urandom_range(0, HOT_PIXELS - 1)]
                                           : 8'($urandom);
                roll = $urandom_range(0, 99);
                if (roll < 20)
                    colour = shown_px[pix];
                else if (roll < 35)
                    colour = pending_px[pix];
                else
                    colour = COLOR_IN_W'($urandom);
                send_pixel_item(OP_WRITE, pix[3:0], pix[7:4], colour);
                sent++;
            end
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tuser  = OP_WRITE;
        i_s_axis_tdata  = '0;
        for (int i = 0; i < PIXELS; i++) begin
            shown_px[i]   = '0;
            pending_px[i] = '0;
            dirty_px[i]   = 1'b0;
        end
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // the block holds tready low through its clearing pass
        test_write_rules();
        test_drain_order();
        test_random_traffic(36, 53);
        test_random_traffic(53, 36);
        test_random_traffic(0, 0);

        i_s_axis_tvalid <= 1'b0;
        while (flush_queue.size() != 0) @(negedge i_clk);
        // leave room for any stray item
        repeat (12) @(negedge i_clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/dpft_pkg.sv
rtl/core/dpft_ram.sv
rtl/core/dpft_ctrl.sv
rtl/core/dpft_datapath.sv
rtl/core/dirty_pixel_flush_tracker.sv
tb/dirty_pixel_flush_tracker_tb.sv
